### src/lu8d_pkg.sv
package lu8d_pkg;

   localparam int ByteWidth         = 8;
   localparam int CpWidth           = 21;
   localparam int MaxResults        = 3;
   localparam int DefaultQueueDepth = 4;

   localparam logic [ByteWidth-1:0] LeadTwo    = 8'hC0;
   localparam logic [ByteWidth-1:0] LeadThree  = 8'hE0;
   localparam logic [ByteWidth-1:0] LeadFour   = 8'hF0;
   localparam logic [ByteWidth-1:0] LowSixMask = 8'h3F;

   typedef logic [1:0] idx_type;

   // One accepted byte that yields results: up to three code points,
   // the index of the last one and whether the string ends with it.
   typedef struct packed {
      logic [MaxResults-1:0][CpWidth-1:0] cp;
      idx_type                            last_idx;
      logic                               fin;
   } cmd_type;

   function automatic logic [1:0] extra_for(input logic [ByteWidth-1:0] b);
      logic [1:0] ex;
      if (b >= LeadFour) begin
         ex = 2'd3;
      end else if (b >= LeadThree) begin
         ex = 2'd2;
      end else if (b >= LeadTwo) begin
         ex = 2'd1;
      end else begin
         ex = 2'd0;
      end
      return ex;
   endfunction

   function automatic logic [ByteWidth-1:0] lead_bits(input logic [ByteWidth-1:0] b,
                                                      input logic [1:0] ex);
      return b & (LowSixMask >> ex);
   endfunction

endpackage

### src/lenient_utf8_decoder.sv
// Channel    Direction  Handshake             Beat contents
// req        in         req_valid/req_stall   req_data_byte, req_final_byte
// rsp        out        rsp_valid/rsp_stall   rsp_code_point, rsp_run_last, rsp_string_done
//
// One byte is accepted per cycle while the command queue has room; the byte's
// results enter the queue at the same edge and reach rsp once they are at its head.
// The back end gives one result beat per cycle while rsp_stall is low, so a byte
// with three results holds the rsp side for three beats; the queue depth sets how many
// result entries req may run ahead of a stalled rsp side. Synchronous reset empties the
// queue and closes any open sequence; req_stall is high only while the queue is full.
module lenient_utf8_decoder
   import lu8d_pkg::*;
#(
   parameter int QueueDepth = DefaultQueueDepth
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ByteWidth-1:0] req_data_byte,
   input  logic                 req_final_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CpWidth-1:0]   rsp_code_point,
   output logic                 rsp_run_last,
   output logic                 rsp_string_done
);

   logic    accept;
   logic    cmd_valid;
   cmd_type cmd;
   cmd_type head;
   logic    q_empty;
   logic    q_full;
   logic    pop;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   lu8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   lu8d_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && cmd_valid),
      .wr_data (cmd),
      .rd_en   (pop),
      .head    (head),
      .empty   (q_empty),
      .full    (q_full)
   );

   lu8d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (q_empty),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_code_point  (rsp_code_point),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done),
      .pop             (pop)
   );

   // A final byte always yields at least one result.
   a_final_yields: assert property (@(posedge clock) disable iff (reset)
      accept && req_final_byte |=> !q_empty)
      else $error("final byte left no result in the queue");

   // Later results of the same byte must follow a non-last beat.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid)
      else $error("result run broken before its last beat");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_run_last)
      else $error("string end flagged on a beat that is not last of its run");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");

endmodule

### src/lu8d_front.sv
module lu8d_front
   import lu8d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [ByteWidth-1:0] data_byte,
   input  logic                 final_byte,
   output logic                 cmd_valid,
   output cmd_type              cmd
);

   logic [1:0]           wanted_ff, wanted_in;
   logic [1:0]           held_ff, held_in;
   logic [CpWidth-1:0]   partial_ff, partial_in;
   logic [ByteWidth-1:0] lead_ff, lead_in;
   logic [ByteWidth-1:0] second_ff, second_in;

   logic [1:0]           ex;
   logic [1:0]           held_next;
   logic [CpWidth-1:0]   shifted;
   logic [CpWidth-1:0]   byte_cp;

   always_comb begin
      ex        = extra_for(data_byte);
      held_next = held_ff + 2'd1;
      shifted   = {partial_ff[CpWidth-7:0], data_byte[5:0]};
      byte_cp   = CpWidth'(data_byte);

      wanted_in  = wanted_ff;
      held_in    = held_ff;
      partial_in = partial_ff;
      lead_in    = lead_ff;
      second_in  = second_ff;

      cmd_valid    = 1'b0;
      cmd.cp       = '0;
      cmd.last_idx = 2'd0;
      cmd.fin      = final_byte;

      if (wanted_ff == 2'd0) begin
         if (ex == 2'd0 || final_byte) begin
            cmd_valid = 1'b1;
            cmd.cp[0] = byte_cp;
         end else begin
            wanted_in  = ex;
            held_in    = 2'd0;
            lead_in    = data_byte;
            partial_in = CpWidth'(lead_bits(data_byte, ex));
         end
      end else begin
         partial_in = shifted;
         held_in    = held_next;
         if (held_next >= wanted_ff) begin
            cmd_valid  = 1'b1;
            cmd.cp[0]  = shifted;
            wanted_in  = 2'd0;
            held_in    = 2'd0;
            partial_in = '0;
         end else begin
            if (held_next == 2'd1) begin
               second_in = data_byte;
            end
            if (final_byte) begin
               // The sequence is cut short: the lead goes out raw and the
               // bytes after it are decoded again on their own.
               cmd_valid = 1'b1;
               cmd.cp[0] = CpWidth'(lead_ff);
               if (held_next == 2'd1) begin
                  cmd.cp[1]    = byte_cp;
                  cmd.last_idx = 2'd1;
               end else begin
                  case (second_ff) inside
                     [LeadTwo : LeadThree - 8'd1]: begin
                        cmd.cp[1]    = CpWidth'({lead_bits(second_ff, 2'd1),
                                                 data_byte[5:0]});
                        cmd.last_idx = 2'd1;
                     end
                     default: begin
                        cmd.cp[1]    = CpWidth'(second_ff);
                        cmd.cp[2]    = byte_cp;
                        cmd.last_idx = 2'd2;
                     end
                  endcase
               end
            end
         end
      end

      if (final_byte) begin
         wanted_in  = 2'd0;
         held_in    = 2'd0;
         partial_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff  <= 2'd0;
         held_ff    <= 2'd0;
         partial_ff <= '0;
      end else if (accept) begin
         wanted_ff  <= wanted_in;
         held_ff    <= held_in;
         partial_ff <= partial_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lead_ff   <= lead_in;
         second_ff <= second_in;
      end
   end

endmodule

### src/lu8d_queue.sv
module lu8d_queue
   import lu8d_pkg::*;
#(
   parameter int Depth = DefaultQueueDepth
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   input  logic    rd_en,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   cmd_type                entry_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
      logic [PtrWidth-1:0] n;
      if (p == PtrWidth'(Depth - 1)) begin
         n = '0;
      end else begin
         n = p + PtrWidth'(1);
      end
      return n;
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CountWidth'(Depth));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + CountWidth'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### src/lu8d_back.sv
module lu8d_back
   import lu8d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            head,
   input  logic               empty,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [CpWidth-1:0] rsp_code_point,
   output logic               rsp_run_last,
   output logic               rsp_string_done,
   output logic               pop
);

   idx_type idx_ff, idx_in;
   logic    fire;

   assign rsp_valid       = !empty;
   assign rsp_code_point  = head.cp[idx_ff];
   assign rsp_run_last    = (idx_ff == head.last_idx);
   assign rsp_string_done = rsp_run_last && head.fin;
   assign fire            = rsp_valid && !rsp_stall;
   assign pop             = fire && rsp_run_last;

   always_comb begin
      idx_in = idx_ff;
      if (fire) begin
         idx_in = rsp_run_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
